>>> rtl/tbcd_pkg.sv
package tbcd_pkg;

    localparam int VALUE_W  = 32;
    localparam int NIBBLE_W = 4;
    localparam int OCTET_W  = 8;

    localparam logic [NIBBLE_W-1:0] FILLER = 4'hF;

    typedef struct packed {
        logic ready;
        logic load;
        logic shift;
        logic align;
        logic push_len;
        logic push_oct;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last_bit;
        logic out_free;
        logic no_digits;
        logic last_octet;
    } ctl_sts_t;

endpackage

>>> rtl/tbcd_in_if.sv
interface tbcd_in_if;
    import tbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

>>> rtl/tbcd_out_if.sv
interface tbcd_out_if;
    import tbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [OCTET_W-1:0] out_byte;
    logic               is_length;
    logic               last;

    modport source (output valid, output out_byte, output is_length, output last, input ready);
    modport sink (input valid, input out_byte, input is_length, input last, output ready);
endinterface

>>> rtl/tbcd_ctrl.sv
module tbcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  tbcd_pkg::ctl_sts_t sts,
    output tbcd_pkg::ctl_cmd_t cmd
);
    import tbcd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_ALIGN = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_OCT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd          = '0;
        cmd.ready    = (state_reg == S_IDLE);
        cmd.load     = (state_reg == S_IDLE) && sts.in_valid;
        cmd.shift    = (state_reg == S_CONV);
        cmd.align    = (state_reg == S_ALIGN);
        cmd.push_len = (state_reg == S_LEN) && sts.out_free;
        cmd.push_oct = (state_reg == S_OCT) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (sts.last_bit)
                begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                state_next = S_LEN;
            end
            S_LEN:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.no_digits ? S_IDLE : S_OCT;
                end
            end
            S_OCT:
            begin
                if (sts.out_free && sts.last_octet)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/tbcd_dp.sv
module tbcd_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tbcd_pkg::ctl_cmd_t cmd,
    output tbcd_pkg::ctl_sts_t sts,
    tbcd_in_if.sink            number,
    tbcd_out_if.source         octets
);
    import tbcd_pkg::*;

    // Only the low bits of the input that both the parameter and the port allow are used.
    localparam int USE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int NDIG     = ((USE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W    = NDIG * NIBBLE_W;
    localparam int CNT_W    = $clog2(USE_BITS + 1);
    localparam int ND_W     = $clog2(NDIG + 1);

    logic [USE_BITS-1:0] val_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ND_W-1:0]     ndig_reg;

    logic                out_valid_reg;
    logic [OCTET_W-1:0]  out_byte_reg;
    logic                is_length_reg;
    logic                last_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [ND_W-1:0]     lead_cnt;
    logic [ND_W-1:0]     shift_dig;
    logic [ND_W:0]       len_sum;
    logic [NIBBLE_W-1:0] lo_dig;
    logic [NIBBLE_W-1:0] hi_dig;
    logic                out_free;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*NIBBLE_W +: NIBBLE_W] >= 4'd5)
            begin
                bcd_adj[i*NIBBLE_W +: NIBBLE_W] = bcd_reg[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*NIBBLE_W +: NIBBLE_W] = bcd_reg[i*NIBBLE_W +: NIBBLE_W];
            end
        end
    end

    always_comb
    begin
        lead_cnt = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*NIBBLE_W +: NIBBLE_W] != '0)
            begin
                lead_cnt = ND_W'(i + 1);
            end
        end
    end

    assign shift_dig = ND_W'(NDIG) - lead_cnt;
    assign len_sum   = {1'b0, ndig_reg} + (ND_W + 1)'(1);
    assign lo_dig    = bcd_reg[BCD_W-1 -: NIBBLE_W];
    assign hi_dig    = (ndig_reg >= ND_W'(2)) ? bcd_reg[BCD_W-NIBBLE_W-1 -: NIBBLE_W] : FILLER;
    assign out_free  = !out_valid_reg || octets.ready;

    always_comb
    begin
        sts            = '0;
        sts.in_valid   = number.valid;
        sts.last_bit   = (cnt_reg == CNT_W'(1));
        sts.out_free   = out_free;
        sts.no_digits  = (ndig_reg == '0);
        sts.last_octet = (ndig_reg <= ND_W'(2));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= number.value[USE_BITS-1:0];
            bcd_reg <= '0;
            cnt_reg <= CNT_W'(USE_BITS);
        end
        else if (cmd.shift)
        begin
            val_reg <= {val_reg[USE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], val_reg[USE_BITS-1]};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.align)
        begin
            bcd_reg  <= bcd_reg << {shift_dig, 2'b00};
            ndig_reg <= lead_cnt;
        end
        else if (cmd.push_oct)
        begin
            bcd_reg  <= bcd_reg << OCTET_W;
            ndig_reg <= (ndig_reg >= ND_W'(2)) ? ndig_reg - ND_W'(2) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_len)
        begin
            out_byte_reg  <= OCTET_W'(len_sum[ND_W:1]);
            is_length_reg <= 1'b1;
            last_reg      <= (ndig_reg == '0);
        end
        else if (cmd.push_oct)
        begin
            out_byte_reg  <= {hi_dig, lo_dig};
            is_length_reg <= 1'b0;
            last_reg      <= (ndig_reg <= ND_W'(2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_len || cmd.push_oct)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (octets.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign number.ready     = cmd.ready;
    assign octets.valid     = out_valid_reg;
    assign octets.out_byte  = out_byte_reg;
    assign octets.is_length = is_length_reg;
    assign octets.last      = last_reg;

endmodule

>>> rtl/binary_to_tbcd_encoder_core.sv
// Channel   Role     Beat contents
// number    sink     value: unsigned binary number
// octets    source   out_byte, is_length, last: length octet, then any packed digit octets
//
// An input beat is taken only when the converter is idle. The conversion then runs
// one double-dabble shift per used input bit (32 for the default), one step to
// strip leading zeros, and one to six output beats.
// The output register lets the next number be taken while the final beat waits.
// Reset clears the controller and the output valid flag; a stalled output holds
// the controller in place.
module binary_to_tbcd_encoder_core #(
    parameter int VALUE_BITS = 32
) (
    input logic        clk,
    input logic        rst_n,
    tbcd_in_if.sink    number,
    tbcd_out_if.source octets
);
    import tbcd_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    tbcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tbcd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .number (number),
        .octets (octets)
    );

endmodule

>>> tb/sv/tb_binary_to_tbcd_encoder_core.sv
`timescale 1ns / 1ps

module tb_binary_to_tbcd_encoder_core;
    import tbcd_pkg::*;

    localparam int          TB_VALUE_BITS  = 32;
    localparam logic [63:0] VALUE_MASK     = (TB_VALUE_BITS >= 64) ? ~64'd0 :
                                             ((64'd1 << TB_VALUE_BITS) - 64'd1);
    localparam int          MAX_OCTETS     = 5;
    localparam int          RADIX          = 10;
    localparam logic [7:0]  OVERFLOW_OCTET = 8'hFF;
    localparam int          RANDOM_NUMBERS = 460;
    localparam int          QUIET_TAIL     = 40;
    localparam int          HOLD_AFTER     = 60;
    localparam int          HOLD_CYCLES    = 250;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [OCTET_W-1:0] out_byte;
        logic               is_length;
        logic               last;
    } octet_t;

    logic clk;
    logic rst_n;

    tbcd_in_if  number_if ();
    tbcd_out_if octets_if ();

    binary_to_tbcd_encoder_core #(
        .VALUE_BITS (TB_VALUE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .octets (octets_if)
    );

    logic [VALUE_W-1:0] pending_numbers[$];
    octet_t             tbcd_expected[$];
    int                 total_numbers;
    int                 numbers_taken;
    int                 octets_checked;
    int                 odd_strings;
    int                 zero_numbers;
    int                 mismatch_count;
    int                 send_gap;
    int                 recv_stall;
    int                 cycle_count;
    logic               recv_hold;

    function automatic void predict_tbcd(input logic [VALUE_W-1:0] number);
        logic [63:0]         rest;
        logic [NIBBLE_W-1:0] digits[20];
        logic [NIBBLE_W-1:0] hi;
        int                  ndig;
        int                  noct;
        int                  pos;
        rest = 64'(number) & VALUE_MASK;
        ndig = 0;
        while (rest != 64'd0 && ndig < 20)
        begin
            digits[ndig] = NIBBLE_W'(rest % RADIX);
            rest         = rest / RADIX;
            ndig++;
        end
        noct = (ndig + 1) / 2;
        if (ndig == 0)
        begin
            tbcd_expected.push_back('{8'h00, 1'b1, 1'b1});
            zero_numbers++;
        end
        else if (noct > MAX_OCTETS)
        begin
            tbcd_expected.push_back('{OVERFLOW_OCTET, 1'b1, 1'b1});
        end
        else
        begin
            tbcd_expected.push_back('{OCTET_W'(noct), 1'b1, 1'b0});
            for (int k = 0; k < noct; k++)
            begin
                pos = ndig - 1 - 2 * k;
                hi  = (pos >= 1) ? digits[pos - 1] : FILLER;
                tbcd_expected.push_back('{{hi, digits[pos]}, 1'b0, k == noct - 1});
            end
            if (ndig % 2 == 1)
                odd_strings++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        logic [63:0] lo_bound;
        logic [63:0] hi_bound;
        int          ndig;
        rst_n              = 1'b0;
        pending_numbers = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7, 32'd42,
                            32'd12345, 32'd123456, 32'd999999999, 32'd1000000000,
                            32'd1234567890, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000,
                            32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'd9876543};
        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            case ($urandom_range(0, 9))
                0: pending_numbers.push_back($urandom());
                1: pending_numbers.push_back(($urandom_range(0, 3) == 0) ? 32'd0 :
                                             VALUE_W'($urandom_range(1, 9)));
                default:
                begin
                    ndig     = $urandom_range(1, 10);
                    lo_bound = 64'd1;
                    for (int d = 1; d < ndig; d++)
                        lo_bound = lo_bound * RADIX;
                    hi_bound = lo_bound * RADIX - 64'd1;
                    if (hi_bound > 64'hFFFFFFFF)
                        hi_bound = 64'hFFFFFFFF;
                    pending_numbers.push_back($urandom_range(32'(hi_bound), 32'(lo_bound)));
                end
            endcase
        end
        total_numbers = pending_numbers.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (numbers_taken < total_numbers || tbcd_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count = mismatch_count + tbcd_expected.size();
        $display("Converted %0d numbers (%0d zero, %0d with an odd digit count)",
                 numbers_taken, zero_numbers, odd_strings);
        $display("Checked %0d octets, including one long output hold-off", octets_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        recv_hold = 1'b0;
        while (numbers_taken < HOLD_AFTER)
            @(posedge clk);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin : number_driver
        logic next_valid;
        logic quiet;
        if (!rst_n)
        begin
            number_if.valid <= 1'b0;
            number_if.value <= '0;
            send_gap        = 0;
            numbers_taken   <= 0;
        end
        else if (!number_if.valid || number_if.ready)
        begin
            if (number_if.valid)
            begin
                predict_tbcd(number_if.value);
                numbers_taken <= numbers_taken + 1;
            end
            quiet      = numbers_taken >= total_numbers - QUIET_TAIL;
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_numbers.size() != 0)
            begin
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 5) - 1;
                else
                begin
                    next_valid = 1'b1;
                    number_if.value <= pending_numbers.pop_front();
                end
            end
            number_if.valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : octet_monitor
        octet_t got;
        octet_t want;
        logic   quiet;
        if (!rst_n)
        begin
            octets_if.ready <= 1'b0;
            recv_stall      = 0;
        end
        else
        begin
            if (octets_if.valid && octets_if.ready)
            begin
                got = '{octets_if.out_byte, octets_if.is_length, octets_if.last};
                octets_checked++;
                if (tbcd_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected octet: out_byte=%h is_length=%b last=%b",
                                 got.out_byte, got.is_length, got.last);
                end
                else
                begin
                    want = tbcd_expected.pop_front();
                    if (got != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Octet mismatch: expected out_byte=%h is_length=%b ",
                                      "last=%b, got out_byte=%h is_length=%b last=%b"},
                                     want.out_byte, want.is_length, want.last,
                                     got.out_byte, got.is_length, got.last);
                    end
                end
            end
            quiet = numbers_taken >= total_numbers - QUIET_TAIL;
            if (recv_hold)
                octets_if.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                octets_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                recv_stall = $urandom_range(1, 5) - 1;
                octets_if.ready <= 1'b0;
            end
            else
                octets_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
